@@ hw/rtl/wgs_pkg.sv @@
// Package for the wave equation grid stepper: codes, reset values, types
// and the saturation helper. No dependencies.
package wgs_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_STEP  = 2'd2;

    localparam logic [1:0] REPLY_WRITE = 2'd0;
    localparam logic [1:0] REPLY_READ  = 2'd1;
    localparam logic [1:0] REPLY_STEP  = 2'd2;

    localparam logic [2:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_COUPLING    = 3'd2;
    localparam logic [2:0] CFG_TIME_STEP   = 3'd3;
    localparam logic [2:0] CFG_DAMPING     = 3'd4;

    localparam logic [8:0]  RST_GRID_WIDTH  = 9'd256;
    localparam logic [8:0]  RST_GRID_HEIGHT = 9'd256;
    localparam logic [24:0] RST_COUPLING    = 25'd1638400;
    localparam logic [15:0] RST_TIME_STEP   = 16'd655;
    localparam logic [16:0] RST_DAMPING     = 17'd64880;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WALL_RD,
        ST_WALL_WR,
        ST_LAP,
        ST_LAP_MUL,
        ST_LAP_WR,
        ST_POS_RD,
        ST_POS_MUL,
        ST_POS_WR,
        ST_DAMP_RD,
        ST_DAMP_MUL,
        ST_DAMP_WR,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic signed [31:0] disp;
        logic signed [31:0] vel;
        logic               wall;
    } t_cell;

    typedef struct packed {
        logic disp;
        logic vel;
        logic wall;
    } t_wr_en;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

endpackage

@@ hw/rtl/wgs_mem.sv @@
// Cell store: displacement, velocity and wall arrays with one write port
// and one registered read port. Depends on wgs_pkg.
module wgs_mem #(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic               i_clk,
    input  logic [AW-1:0]      i_rd_addr,
    input  logic [AW-1:0]      i_wr_addr,
    input  wgs_pkg::t_wr_en    i_wr_en,
    input  wgs_pkg::t_cell     i_wr_data,
    output wgs_pkg::t_cell     o_rd_data
);

    logic [31:0] mem_disp [DEPTH];
    logic [31:0] mem_vel  [DEPTH];
    logic        mem_wall [DEPTH];
    wgs_pkg::t_cell r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en.disp) begin
            mem_disp[i_wr_addr] <= i_wr_data.disp;
        end
        if (i_wr_en.vel) begin
            mem_vel[i_wr_addr] <= i_wr_data.vel;
        end
        if (i_wr_en.wall) begin
            mem_wall[i_wr_addr] <= i_wr_data.wall;
        end
        r_rd.disp <= mem_disp[i_rd_addr];
        r_rd.vel  <= mem_vel[i_rd_addr];
        r_rd.wall <= mem_wall[i_rd_addr];
    end

    assign o_rd_data = r_rd;

endmodule

@@ hw/rtl/wave_equation_grid_step_top.sv @@
// Top level of the wave equation grid stepper: request sequencer, step
// arithmetic and configuration registers. Depends on wgs_pkg and wgs_mem.
//
// An item is taken at a clock edge where start is high and busy is low.
// Each item except the unused request code gives one reply, shown for one
// cycle with o_done high; the receiver cannot stall it.
// A write is answered in the cycle after it is taken and busy stays low, so
// the next item may follow at once. A read is answered through the registered
// read of the store and then the reply register.
// A step runs four passes over the store, each one cell at a time through
// the single read port: for the wall pass a read per cell of the region and
// a write if it is a wall; for the stencil pass five reads, a multiply and a
// write per interior cell; for each of the last two passes a read, a
// multiply and a write per interior cell. A region under 3 wide or high
// gets the wall pass alone, an empty one no pass. After reset a clearing
// pass writes zeros to every entry, one a cycle, with busy high;
// configuration writes are taken at any time and act at once.
module wave_equation_grid_step_top #(
    parameter int MAX_WIDTH  = wgs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = wgs_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = wgs_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [7:0]         i_cell_x,
    input  logic [7:0]         i_cell_y,
    input  logic signed [31:0] i_disp_in,
    input  logic signed [31:0] i_vel_in,
    input  logic               i_wall_in,
    output logic               o_done,
    output logic [1:0]         o_reply_kind,
    output logic signed [31:0] o_disp_out,
    output logic signed [31:0] o_vel_out,
    output logic               o_wall_out,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [24:0]        i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    wgs_pkg::t_state r_state, n_state;
    logic [9:0]  r_x, n_x, r_y, n_y;
    logic [2:0]  r_k, n_k;
    logic signed [35:0] r_acc, n_acc;
    logic signed [31:0] r_base, n_base;
    logic [42:0] r_plo, n_plo;
    logic signed [43:0] r_phi, n_phi;
    logic signed [49:0] r_prod, n_prod;
    logic [AW-1:0] r_clr, n_clr;
    logic        r_rd_in, n_rd_in;
    logic        r_done, n_done;
    logic [1:0]  r_kind, n_kind;
    logic signed [31:0] r_disp, n_disp, r_vel, n_vel;
    logic        r_wall, n_wall;

    logic [8:0]  r_gw, r_gh;
    logic [24:0] r_coup;
    logic [15:0] r_ts;
    logic [16:0] r_damp;

    logic [9:0]  w, h;
    logic [AW-1:0] center, req_addr, rd_addr, wr_addr;
    logic        req_in, accept;
    logic signed [63:0] lap_sum;
    wgs_pkg::t_wr_en wr_en;
    wgs_pkg::t_cell  wr_data, rd_data;

    assign w = (int'(r_gw) > MAX_WIDTH) ? 10'(MAX_WIDTH) : {1'b0, r_gw};
    assign h = (int'(r_gh) > MAX_HEIGHT) ? 10'(MAX_HEIGHT) : {1'b0, r_gh};
    assign center = AW'(r_y) * AW'(MAX_WIDTH) + AW'(r_x);
    assign req_addr = AW'(i_cell_y) * AW'(MAX_WIDTH) + AW'(i_cell_x);
    assign req_in = (int'(i_cell_x) < MAX_WIDTH) && (int'(i_cell_y) < MAX_HEIGHT);
    assign busy = (r_state != wgs_pkg::ST_IDLE);
    assign accept = start && !busy;
    assign lap_sum = (64'(r_phi) <<< 18) + $signed({21'b0, r_plo});

    wgs_mem #(
        .DEPTH(DEPTH),
        .AW(AW)
    ) u_mem (
        .i_clk(i_clk),
        .i_rd_addr(rd_addr),
        .i_wr_addr(wr_addr),
        .i_wr_en(wr_en),
        .i_wr_data(wr_data),
        .o_rd_data(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw   <= wgs_pkg::RST_GRID_WIDTH;
            r_gh   <= wgs_pkg::RST_GRID_HEIGHT;
            r_coup <= wgs_pkg::RST_COUPLING;
            r_ts   <= wgs_pkg::RST_TIME_STEP;
            r_damp <= wgs_pkg::RST_DAMPING;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                wgs_pkg::CFG_GRID_WIDTH:  r_gw   <= i_cfg_data[8:0];
                wgs_pkg::CFG_GRID_HEIGHT: r_gh   <= i_cfg_data[8:0];
                wgs_pkg::CFG_COUPLING:    r_coup <= i_cfg_data;
                wgs_pkg::CFG_TIME_STEP:   r_ts   <= i_cfg_data[15:0];
                wgs_pkg::CFG_DAMPING:     r_damp <= i_cfg_data[16:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wgs_pkg::ST_CLEAR;
            r_clr   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_done  <= n_done;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_k     <= n_k;
        r_acc   <= n_acc;
        r_base  <= n_base;
        r_plo   <= n_plo;
        r_phi   <= n_phi;
        r_prod  <= n_prod;
        r_rd_in <= n_rd_in;
        r_kind  <= n_kind;
        r_disp  <= n_disp;
        r_vel   <= n_vel;
        r_wall  <= n_wall;
    end

    always_comb begin
        n_state = r_state;
        n_x     = r_x;
        n_y     = r_y;
        n_k     = r_k;
        n_acc   = r_acc;
        n_base  = r_base;
        n_plo   = r_plo;
        n_phi   = r_phi;
        n_prod  = r_prod;
        n_clr   = r_clr;
        n_rd_in = r_rd_in;
        n_done  = 1'b0;
        n_kind  = r_kind;
        n_disp  = r_disp;
        n_vel   = r_vel;
        n_wall  = r_wall;
        rd_addr = center;
        wr_addr = center;
        wr_en   = '0;
        wr_data = '0;
        unique case (r_state)
            wgs_pkg::ST_CLEAR: begin
                wr_en   = '1;
                wr_addr = r_clr;
                n_clr   = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = wgs_pkg::ST_IDLE;
                end
            end
            wgs_pkg::ST_IDLE: begin
                rd_addr = req_addr;
                if (accept) begin
                    case (i_req_type)
                        wgs_pkg::REQ_WRITE: begin
                            wr_addr      = req_addr;
                            wr_en        = req_in ? '1 : '0;
                            wr_data.disp = i_disp_in;
                            wr_data.vel  = i_vel_in;
                            wr_data.wall = i_wall_in;
                            n_done = 1'b1;
                            n_kind = wgs_pkg::REPLY_WRITE;
                            n_disp = '0;
                            n_vel  = '0;
                            n_wall = 1'b0;
                        end
                        wgs_pkg::REQ_READ: begin
                            n_rd_in = req_in;
                            n_state = wgs_pkg::ST_READ;
                        end
                        wgs_pkg::REQ_STEP: begin
                            n_x = '0;
                            n_y = '0;
                            if (w == 10'd0 || h == 10'd0) begin
                                n_state = wgs_pkg::ST_DONE;
                            end else begin
                                n_state = wgs_pkg::ST_WALL_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            wgs_pkg::ST_READ: begin
                n_done  = 1'b1;
                n_kind  = wgs_pkg::REPLY_READ;
                n_disp  = r_rd_in ? rd_data.disp : '0;
                n_vel   = r_rd_in ? rd_data.vel : '0;
                n_wall  = r_rd_in ? rd_data.wall : 1'b0;
                n_state = wgs_pkg::ST_IDLE;
            end
            wgs_pkg::ST_WALL_RD: begin
                n_state = wgs_pkg::ST_WALL_WR;
            end
            wgs_pkg::ST_WALL_WR: begin
                if (rd_data.wall) begin
                    wr_en.disp = 1'b1;
                    wr_en.vel  = 1'b1;
                end
                n_state = wgs_pkg::ST_WALL_RD;
                if (r_x + 10'd1 < w) begin
                    n_x = r_x + 10'd1;
                end else begin
                    n_x = '0;
                    if (r_y + 10'd1 < h) begin
                        n_y = r_y + 10'd1;
                    end else if (w < 10'd3 || h < 10'd3) begin
                        n_state = wgs_pkg::ST_DONE;
                    end else begin
                        n_x = 10'd1;
                        n_y = 10'd1;
                        n_k = '0;
                        n_state = wgs_pkg::ST_LAP;
                    end
                end
            end
            wgs_pkg::ST_LAP: begin
                case (r_k)
                    3'd1:    rd_addr = center - AW'(1);
                    3'd2:    rd_addr = center + AW'(1);
                    3'd3:    rd_addr = center - AW'(MAX_WIDTH);
                    3'd4:    rd_addr = center + AW'(MAX_WIDTH);
                    default: rd_addr = center;
                endcase
                if (r_k == 3'd1) begin
                    n_acc  = -(36'(rd_data.disp) <<< 2);
                    n_base = rd_data.vel;
                end else if (r_k != 3'd0) begin
                    n_acc = r_acc + 36'(rd_data.disp);
                end
                if (r_k == 3'd5) begin
                    n_state = wgs_pkg::ST_LAP_MUL;
                end else begin
                    n_k = r_k + 3'd1;
                end
            end
            wgs_pkg::ST_LAP_MUL: begin
                n_plo = 43'(r_acc[17:0]) * 43'(r_coup);
                n_phi = 44'($signed(r_acc[35:18])) * 44'($signed({1'b0, r_coup}));
                n_state = wgs_pkg::ST_LAP_WR;
            end
            wgs_pkg::ST_LAP_WR: begin
                wr_en.vel   = 1'b1;
                wr_data.vel = wgs_pkg::sat32(64'(r_base) + (lap_sum >>> FRAC_BITS));
                n_k = '0;
                n_state = wgs_pkg::ST_LAP;
                if (r_x + 10'd2 < w) begin
                    n_x = r_x + 10'd1;
                end else begin
                    n_x = 10'd1;
                    if (r_y + 10'd2 < h) begin
                        n_y = r_y + 10'd1;
                    end else begin
                        n_y = 10'd1;
                        n_state = wgs_pkg::ST_POS_RD;
                    end
                end
            end
            wgs_pkg::ST_POS_RD: begin
                n_state = wgs_pkg::ST_POS_MUL;
            end
            wgs_pkg::ST_POS_MUL: begin
                n_prod  = 50'($signed({1'b0, r_ts})) * 50'(rd_data.vel);
                n_base  = rd_data.disp;
                n_state = wgs_pkg::ST_POS_WR;
            end
            wgs_pkg::ST_POS_WR: begin
                wr_en.disp   = 1'b1;
                wr_data.disp = wgs_pkg::sat32(64'(r_base) + 64'(r_prod >>> FRAC_BITS));
                n_state = wgs_pkg::ST_POS_RD;
                if (r_x + 10'd2 < w) begin
                    n_x = r_x + 10'd1;
                end else begin
                    n_x = 10'd1;
                    if (r_y + 10'd2 < h) begin
                        n_y = r_y + 10'd1;
                    end else begin
                        n_y = 10'd1;
                        n_state = wgs_pkg::ST_DAMP_RD;
                    end
                end
            end
            wgs_pkg::ST_DAMP_RD: begin
                n_state = wgs_pkg::ST_DAMP_MUL;
            end
            wgs_pkg::ST_DAMP_MUL: begin
                n_prod  = 50'($signed({1'b0, r_damp})) * 50'(rd_data.vel);
                n_state = wgs_pkg::ST_DAMP_WR;
            end
            wgs_pkg::ST_DAMP_WR: begin
                wr_en.vel   = 1'b1;
                wr_data.vel = wgs_pkg::sat32(64'(r_prod >>> FRAC_BITS));
                n_state = wgs_pkg::ST_DAMP_RD;
                if (r_x + 10'd2 < w) begin
                    n_x = r_x + 10'd1;
                end else begin
                    n_x = 10'd1;
                    if (r_y + 10'd2 < h) begin
                        n_y = r_y + 10'd1;
                    end else begin
                        n_state = wgs_pkg::ST_DONE;
                    end
                end
            end
            wgs_pkg::ST_DONE: begin
                n_done  = 1'b1;
                n_kind  = wgs_pkg::REPLY_STEP;
                n_disp  = '0;
                n_vel   = '0;
                n_wall  = 1'b0;
                n_state = wgs_pkg::ST_IDLE;
            end
            default: n_state = wgs_pkg::ST_IDLE;
        endcase
    end

    assign o_done       = r_done;
    assign o_reply_kind = r_kind;
    assign o_disp_out   = r_disp;
    assign o_vel_out    = r_vel;
    assign o_wall_out   = r_wall;

`ifndef SYNTHESIS
    a_step_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req_type == wgs_pkg::REQ_STEP |=> busy)
        else $error("step item did not raise busy");

    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_reply_kind != wgs_pkg::REPLY_READ |->
        o_disp_out == 0 && o_vel_out == 0 && !o_wall_out)
        else $error("non-read reply carries data");

    a_no_reply_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == wgs_pkg::ST_CLEAR |-> !o_done)
        else $error("reply during clearing pass");

    a_read_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_req_type == wgs_pkg::REQ_READ |=> ##1
        o_done && o_reply_kind == wgs_pkg::REPLY_READ)
        else $error("read reply missing");
`endif

endmodule

@@ tb/wave_equation_grid_step_top_tb.sv @@
`timescale 1ns / 1ps
// Testbench for wave_equation_grid_step_top: drives cell writes, reads and time steps,
// keeps its own copy of the grid and checks every reply field by field.
// Depends on wgs_pkg and the RTL of the grid stepper.
module wave_equation_grid_step_top_tb;

    localparam int GRID_DIM = 256;
    localparam int FRAC = wgs_pkg::FRAC_BITS_DEF;
    localparam int IDLE_LIMIT = 200000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] disp;
        logic signed [31:0] vel;
        logic               wall;
    } t_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_req_type = wgs_pkg::REQ_WRITE;
    logic [7:0]         i_cell_x = '0;
    logic [7:0]         i_cell_y = '0;
    logic signed [31:0] i_disp_in = '0;
    logic signed [31:0] i_vel_in = '0;
    logic               i_wall_in = 1'b0;
    logic               o_done;
    logic [1:0]         o_reply_kind;
    logic signed [31:0] o_disp_out;
    logic signed [31:0] o_vel_out;
    logic               o_wall_out;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [24:0]        i_cfg_data = '0;

    logic signed [31:0] disp_grid [GRID_DIM*GRID_DIM];
    logic signed [31:0] vel_grid [GRID_DIM*GRID_DIM];
    logic               wall_grid [GRID_DIM*GRID_DIM];
    int unsigned        region_w = wgs_pkg::RST_GRID_WIDTH;
    int unsigned        region_h = wgs_pkg::RST_GRID_HEIGHT;
    longint             coupling_q = wgs_pkg::RST_COUPLING;
    longint             time_step_q = wgs_pkg::RST_TIME_STEP;
    longint             damping_q = wgs_pkg::RST_DAMPING;

    t_reply pending_replies [$];
    int     error_count = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;

    wave_equation_grid_step_top i_dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint disp_val(input int x, input int y);
        return longint'(disp_grid[y*GRID_DIM + x]);
    endfunction

    function automatic void advance_grid();
        int w;
        int h;
        int idx;
        longint lap;
        w = (region_w > GRID_DIM) ? GRID_DIM : region_w;
        h = (region_h > GRID_DIM) ? GRID_DIM : region_h;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++) begin
                idx = y*GRID_DIM + x;
                if (wall_grid[idx]) begin
                    disp_grid[idx] = '0;
                    vel_grid[idx] = '0;
                end
            end
        for (int y = 1; y + 1 < h; y++)
            for (int x = 1; x + 1 < w; x++) begin
                idx = y*GRID_DIM + x;
                lap = disp_val(x+1, y) + disp_val(x-1, y) + disp_val(x, y+1)
                    + disp_val(x, y-1) - 4*disp_val(x, y);
                vel_grid[idx] = clamp32(longint'(vel_grid[idx]) + ((lap*coupling_q) >>> FRAC));
            end
        for (int y = 1; y + 1 < h; y++)
            for (int x = 1; x + 1 < w; x++) begin
                idx = y*GRID_DIM + x;
                disp_grid[idx] = clamp32(longint'(disp_grid[idx])
                    + ((time_step_q*longint'(vel_grid[idx])) >>> FRAC));
            end
        for (int y = 1; y + 1 < h; y++)
            for (int x = 1; x + 1 < w; x++) begin
                idx = y*GRID_DIM + x;
                vel_grid[idx] = clamp32((longint'(vel_grid[idx])*damping_q) >>> FRAC);
            end
    endfunction

    function automatic void predict_reply(input logic [1:0] req, input logic [7:0] x,
                                          input logic [7:0] y, input logic signed [31:0] d,
                                          input logic signed [31:0] v, input logic wl);
        t_reply r;
        int idx;
        idx = int'(y)*GRID_DIM + int'(x);
        r.kind = req;
        r.disp = '0;
        r.vel = '0;
        r.wall = 1'b0;
        case (req)
            wgs_pkg::REQ_WRITE: begin
                disp_grid[idx] = d;
                vel_grid[idx] = v;
                wall_grid[idx] = wl;
            end
            wgs_pkg::REQ_READ: begin
                r.disp = disp_grid[idx];
                r.vel = vel_grid[idx];
                r.wall = wall_grid[idx];
            end
            wgs_pkg::REQ_STEP: advance_grid();
            default: return;
        endcase
        pending_replies.push_back(r);
    endfunction

    always @(posedge i_clk) begin
        t_reply exp_r;
        if (o_done) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected reply kind %0d", $time, o_reply_kind);
                error_count++;
            end else begin
                exp_r = pending_replies.pop_front();
                if (o_reply_kind !== exp_r.kind) begin
                    $display("%0t: reply_kind expected %0d actual %0d", $time, exp_r.kind,
                             o_reply_kind);
                    error_count++;
                end
                if (o_disp_out !== exp_r.disp) begin
                    $display("%0t: disp_out expected %0d actual %0d", $time, exp_r.disp,
                             o_disp_out);
                    error_count++;
                end
                if (o_vel_out !== exp_r.vel) begin
                    $display("%0t: vel_out expected %0d actual %0d", $time, exp_r.vel,
                             o_vel_out);
                    error_count++;
                end
                if (o_wall_out !== exp_r.wall) begin
                    $display("%0t: wall_out expected %0d actual %0d", $time, exp_r.wall,
                             o_wall_out);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_item(input logic [1:0] req, input logic [7:0] x, input logic [7:0] y,
                             input logic signed [31:0] d, input logic signed [31:0] v,
                             input logic wl);
        int gap;
        start <= 1'b1;
        i_req_type <= req;
        i_cell_x <= x;
        i_cell_y <= y;
        i_disp_in <= d;
        i_vel_in <= v;
        i_wall_in <= wl;
        do @(posedge i_clk); while (busy);
        predict_reply(req, x, y, d, v, wl);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = $urandom_range(1, 5);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [24:0] data);
        wait_quiet();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            wgs_pkg::CFG_GRID_WIDTH:  region_w = data[8:0];
            wgs_pkg::CFG_GRID_HEIGHT: region_h = data[8:0];
            wgs_pkg::CFG_COUPLING:    coupling_q = data;
            wgs_pkg::CFG_TIME_STEP:   time_step_q = data[15:0];
            wgs_pkg::CFG_DAMPING:     damping_q = data[16:0];
            default: ;
        endcase
    endtask

    task automatic set_region(input logic [8:0] w, input logic [8:0] h);
        write_cfg(wgs_pkg::CFG_GRID_WIDTH, 25'(w));
        write_cfg(wgs_pkg::CFG_GRID_HEIGHT, 25'(h));
    endtask

    function automatic logic signed [31:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh1ffff;
        endcase
    endfunction

    task automatic test_cell_access();
        send_item(wgs_pkg::REQ_WRITE, 8'd0, 8'd0, 32'sh7fffffff, 32'sh80000000, 1'b1);
        send_item(wgs_pkg::REQ_WRITE, 8'd255, 8'd255, 32'sh80000000, 32'sh7fffffff, 1'b0);
        send_item(wgs_pkg::REQ_WRITE, 8'd170, 8'd85, 32'sh55555555, -32'sh2aaaaaab, 1'b1);
        send_item(wgs_pkg::REQ_READ, 8'd0, 8'd0, '0, '0, 1'b0);
        send_item(wgs_pkg::REQ_READ, 8'd255, 8'd255, '0, '0, 1'b0);
        send_item(wgs_pkg::REQ_READ, 8'd170, 8'd85, '0, '0, 1'b0);
        send_item(REQ_UNUSED, 8'd12, 8'd34, 32'sd1, 32'sd2, 1'b1);
        send_item(wgs_pkg::REQ_READ, 8'd85, 8'd170, '0, '0, 1'b0);
    endtask

    task automatic test_tiny_region();
        set_region(9'd0, 9'd5);
        send_item(wgs_pkg::REQ_STEP, '0, '0, '0, '0, 1'b0);
        send_item(wgs_pkg::REQ_READ, 8'd0, 8'd0, '0, '0, 1'b0);
        set_region(9'd2, 9'd1);
        send_item(wgs_pkg::REQ_STEP, '0, '0, '0, '0, 1'b0);
        send_item(wgs_pkg::REQ_READ, 8'd0, 8'd0, '0, '0, 1'b0);
    endtask

    task automatic test_step_extremes();
        write_cfg(wgs_pkg::CFG_COUPLING, 25'd16777216);
        write_cfg(wgs_pkg::CFG_TIME_STEP, 25'd65535);
        write_cfg(wgs_pkg::CFG_DAMPING, 25'd65536);
        set_region(9'd3, 9'd3);
        send_item(wgs_pkg::REQ_WRITE, 8'd1, 8'd1, 32'sh00010000, 32'sh7fff0000, 1'b1);
        send_item(wgs_pkg::REQ_WRITE, 8'd0, 8'd1, 32'sh7fffffff, 32'sd0, 1'b0);
        send_item(wgs_pkg::REQ_STEP, '0, '0, '0, '0, 1'b0);
        send_item(wgs_pkg::REQ_READ, 8'd1, 8'd1, '0, '0, 1'b0);
        write_cfg(wgs_pkg::CFG_COUPLING, 25'd0);
        write_cfg(wgs_pkg::CFG_TIME_STEP, 25'd0);
        write_cfg(wgs_pkg::CFG_DAMPING, 25'd0);
        set_region(9'd511, 9'd4);
        send_item(wgs_pkg::REQ_WRITE, 8'd255, 8'd2, 32'sd5, 32'sd7, 1'b0);
        send_item(wgs_pkg::REQ_STEP, '0, '0, '0, '0, 1'b0);
        send_item(wgs_pkg::REQ_READ, 8'd254, 8'd2, '0, '0, 1'b0);
        set_region(9'd3, 9'd256);
        write_cfg(wgs_pkg::CFG_COUPLING, 25'd1638400);
        write_cfg(wgs_pkg::CFG_TIME_STEP, 25'd655);
        write_cfg(wgs_pkg::CFG_DAMPING, 25'd64880);
        send_item(wgs_pkg::REQ_WRITE, 8'd1, 8'd200, 32'sh00030000, 32'sd0, 1'b0);
        send_item(wgs_pkg::REQ_STEP, '0, '0, '0, '0, 1'b0);
        send_item(wgs_pkg::REQ_READ, 8'd1, 8'd200, '0, '0, 1'b0);
    endtask

    task automatic test_random_traffic();
        int w;
        int h;
        int pick;
        for (int round = 0; round < 4; round++) begin
            w = $urandom_range(3, 10);
            h = $urandom_range(3, 10);
            set_region(9'(w), 9'(h));
            write_cfg(wgs_pkg::CFG_COUPLING, 25'($urandom_range(0, 16777216)));
            write_cfg(wgs_pkg::CFG_TIME_STEP, 25'($urandom_range(0, 65535)));
            write_cfg(wgs_pkg::CFG_DAMPING, 25'($urandom_range(0, 65536)));
            for (int n = 0; n < 25; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_item(wgs_pkg::REQ_WRITE, 8'($urandom_range(0, w-1)),
                              8'($urandom_range(0, h-1)),
                              random_value(), random_value(), $urandom_range(0, 4) == 0);
                else if (pick < 70)
                    send_item(wgs_pkg::REQ_READ, 8'($urandom_range(0, w-1)),
                              8'($urandom_range(0, h-1)),
                              $urandom, $urandom, $urandom_range(0, 1));
                else if (pick < 85)
                    send_item(wgs_pkg::REQ_STEP, 8'($urandom), 8'($urandom), $urandom,
                              $urandom, $urandom_range(0, 1));
                else if (pick < 90)
                    send_item(REQ_UNUSED, 8'($urandom), 8'($urandom), $urandom, $urandom,
                              $urandom_range(0, 1));
                else
                    send_item($urandom_range(0, 1) ? wgs_pkg::REQ_READ : wgs_pkg::REQ_WRITE,
                              8'($urandom), 8'($urandom),
                              $urandom, $urandom, $urandom_range(0, 1));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < GRID_DIM*GRID_DIM; i++) begin
            disp_grid[i] = '0;
            vel_grid[i] = '0;
            wall_grid[i] = 1'b0;
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_cell_access();
        test_tiny_region();
        test_step_extremes();
        test_random_traffic();
        wait_quiet();
        repeat (20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ wave_equation_grid_step_top.f @@
hw/rtl/wgs_pkg.sv
hw/rtl/wgs_mem.sv
hw/rtl/wave_equation_grid_step_top.sv
tb/wave_equation_grid_step_top_tb.sv
